FILE: design/lsae_pkg.sv
package lsae_pkg;

  // Command codes carried in the cmd field
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_COLOR  = 3'd3;
  localparam logic [2:0] CMD_BRIGHT = 3'd4;
  localparam logic [2:0] CMD_FADE   = 3'd5;

  // Animation modes
  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_BREATH  = 3'd1;
  localparam logic [2:0] MODE_BLINK   = 3'd2;
  localparam logic [2:0] MODE_PULSE   = 3'd3;
  localparam logic [2:0] MODE_WAVE    = 3'd4;
  localparam logic [2:0] MODE_FADEIN  = 3'd5;
  localparam logic [2:0] MODE_FADEOUT = 3'd6;
  localparam logic [2:0] MODE_ROTATE  = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_RGB      = 3'd1;
  localparam logic [2:0] CFG_DURATION = 3'd2;
  localparam logic [2:0] CFG_PERIOD   = 3'd3;
  localparam logic [2:0] CFG_INTENS   = 3'd4;
  localparam logic [2:0] CFG_LOOP     = 3'd5;
  localparam logic [2:0] CFG_FSTEP    = 3'd6;

  localparam int DEF_PIXELS     = 16;
  localparam int DEF_BRIGHTNESS = 128;
  localparam logic [31:0] REFRESH_MS = 32'd20;

  localparam logic [63:0] PI_OVER_128_Q30 = 64'd26353589;
  localparam logic [63:0] ONE_Q30         = 64'd1073741824;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] now_ms;
    logic [7:0]  level;
    logic [23:0] color;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] global_level;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_FILL, ST_RBRT, ST_RWR, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_SCALE, SEL_RAW, SEL_ZERO
  } sel_t;

  // Controller to datapath
  typedef struct packed {
    logic item_load;
    logic exec;
    logic idx_clr;
    logic idx_inc;
    logic fill_wr;
    logic rend_calc;
    logic rend_wr;
    logic emit_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill;
    logic render;
    logic refresh;
    logic emit_pend;
    logic idx_last;
    logic out_free;
  } dp_stat_t;

  typedef logic [15:0] sine_rom_t [256];

  // sin(k*pi/128) in Q30 by a Taylor series, k in 0..64
  function automatic logic [63:0] sin_q30(input int unsigned k);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    int j;
    a = 64'(k) * PI_OVER_128_Q30;
    a2 = (a * a) >> 30;
    term = a;
    sum = a;
    for (j = 1; j <= 6; j++) begin
      term = ((term * a2) >> 30) / 64'((2 * j) * (2 * j + 1));
      if ((j & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  // Unsigned Q0.16 sine table, evaluated at elaboration
  function automatic sine_rom_t build_sine();
    sine_rom_t t;
    int unsigned p;
    int unsigned idx;
    int unsigned m;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] q;
    for (p = 0; p < 256; p++) begin
      idx = p & 127;
      m = (idx <= 64) ? idx : 128 - idx;
      s = sin_q30(m);
      v = ((p & 128) != 0) ? (ONE_Q30 - s) : (ONE_Q30 + s);
      q = (v + 64'd16384) >> 15;
      if (q > 64'd65535) q = 64'd65535;
      t[p] = q[15:0];
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // floor(c * b / 255) per component
  function automatic logic [23:0] scale_rgb(input logic [23:0] rgb, input logic [7:0] b);
    logic [15:0] x;
    logic [16:0] y;
    logic [23:0] r;
    int k;
    r = '0;
    for (k = 0; k < 3; k++) begin
      x = 16'(rgb[k*8 +: 8]) * 16'(b);
      y = 17'(x) + 17'(x[15:8]) + 17'd1;
      r[k*8 +: 8] = y[15:8];
    end
    return r;
  endfunction

endpackage

FILE: design/lsae_ctrl.sv
module lsae_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsae_pkg::dp_stat_t stat,
  output lsae_pkg::dp_cmd_t  cmd
);
  import lsae_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (stat.fill) state_next = ST_FILL;
        else if (stat.render) state_next = ST_RBRT;
        else if (stat.refresh) state_next = ST_EMIT;
        else state_next = ST_IDLE;
      end
      ST_FILL: if (stat.idx_last) state_next = ST_IDLE;
      ST_RBRT: state_next = ST_RWR;
      ST_RWR: begin
        if (stat.idx_last) state_next = stat.emit_pend ? ST_EMIT : ST_IDLE;
        else state_next = ST_RBRT;
      end
      ST_EMIT: if (stat.out_free && stat.idx_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.item_load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        cmd.idx_clr = 1'b1;
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      ST_RBRT: cmd.rend_calc = 1'b1;
      ST_RWR: begin
        cmd.rend_wr = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_load = stat.out_free;
        cmd.idx_inc = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: design/lsae_dp.sv
module lsae_dp #(
  parameter int PIXELS           = lsae_pkg::DEF_PIXELS,
  parameter int RESET_BRIGHTNESS = lsae_pkg::DEF_BRIGHTNESS
) (
  input  logic                clk,
  input  logic                rst,
  input  lsae_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  lsae_pkg::dp_cmd_t   cmd,
  output lsae_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output lsae_pkg::out_item_t out_data
);
  import lsae_pkg::*;

  localparam int IW = $clog2(PIXELS);
  localparam logic [IW-1:0] CENTER = IW'(PIXELS / 2);
  localparam logic [IW-1:0] LAST_IDX = IW'(PIXELS - 1);

  in_item_t    item;
  logic [2:0]  mode;
  logic [23:0] primary;
  logic [15:0] duration;
  logic [15:0] period;
  logic [7:0]  intens;
  logic        loop_en;
  logic [7:0]  fstep;

  logic [23:0] fb [PIXELS];
  logic [7:0]  cur_level;
  logic [7:0]  tgt_level;
  logic        fading;
  logic        animating;
  logic [31:0] start_stamp;
  logic [31:0] last_frame_stamp;
  logic [31:0] frame_count;
  logic [31:0] last_refresh_stamp;
  logic [IW-1:0] pos;
  logic        half;
  logic [3:0]  blink_cnt;
  logic        blink_ph;
  logic        emit_pend;
  logic [IW-1:0] idx;
  logic [7:0]  bright;
  sel_t        sel;

  logic        is_tick;
  logic        anim_end;
  logic        frame_due;
  logic        refresh_due;
  logic        frame_step;

  // Timing checks on the held item
  assign is_tick     = (item.cmd == CMD_TICK);
  assign anim_end    = !loop_en && ((item.now_ms - start_stamp) >= {16'd0, duration});
  assign frame_due   = (item.now_ms - last_frame_stamp) >= {16'd0, period};
  assign refresh_due = (item.now_ms - last_refresh_stamp) >= REFRESH_MS;
  assign frame_step  = is_tick && animating && !anim_end && frame_due;

  assign stat.fill      = (item.cmd == CMD_COLOR);
  assign stat.render    = frame_step && (mode != MODE_NONE);
  assign stat.refresh   = is_tick && refresh_due;
  assign stat.emit_pend = emit_pend;
  assign stat.idx_last  = (idx == LAST_IDX);
  assign stat.out_free  = !out_valid || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
      primary <= '0;
      duration <= 16'd1000;
      period <= 16'd50;
      intens <= 8'd255;
      loop_en <= 1'b0;
      fstep <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     mode <= cfg_data[2:0];
        CFG_RGB:      primary <= cfg_data;
        CFG_DURATION: duration <= cfg_data[15:0];
        CFG_PERIOD:   period <= cfg_data[15:0];
        CFG_INTENS:   intens <= cfg_data[7:0];
        CFG_LOOP:     loop_en <= cfg_data[0];
        CFG_FSTEP:    fstep <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Held command
  always_ff @(posedge clk) begin
    if (cmd.item_load) item <= in_data;
  end

  // Brightness fade one step toward target
  logic [7:0] fade_level;
  logic       fade_done;
  always_comb begin
    fade_level = cur_level;
    fade_done = 1'b0;
    if (cur_level < tgt_level) begin
      fade_level = ({1'b0, cur_level} + 9'd2 > {1'b0, tgt_level}) ? tgt_level : cur_level + 8'd2;
    end else if (cur_level > tgt_level) begin
      fade_level = ({1'b0, cur_level} < {1'b0, tgt_level} + 9'd2) ? tgt_level : cur_level - 8'd2;
    end else begin
      fade_done = 1'b1;
    end
  end

  // Command execution and animation timing
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level <= 8'(RESET_BRIGHTNESS);
      tgt_level <= 8'(RESET_BRIGHTNESS);
      fading <= 1'b0;
      animating <= 1'b0;
      start_stamp <= '0;
      last_frame_stamp <= '0;
      frame_count <= '0;
      last_refresh_stamp <= '0;
      pos <= '0;
      half <= 1'b0;
      blink_cnt <= '0;
      blink_ph <= 1'b0;
      emit_pend <= 1'b0;
    end else if (cmd.exec) begin
      emit_pend <= 1'b0;
      case (item.cmd)
        CMD_TICK: begin
          if (fading) begin
            cur_level <= fade_level;
            if (fade_done) fading <= 1'b0;
          end
          if (animating && anim_end) animating <= 1'b0;
          if (frame_step) begin
            last_frame_stamp <= item.now_ms;
            frame_count <= frame_count + 32'd1;
            half <= ~half;
            if (half) pos <= (pos == LAST_IDX) ? '0 : pos + 1'b1;
            if (blink_cnt == 4'd9) begin
              blink_cnt <= '0;
              blink_ph <= ~blink_ph;
            end else begin
              blink_cnt <= blink_cnt + 4'd1;
            end
          end
          if (refresh_due) begin
            last_refresh_stamp <= item.now_ms;
            emit_pend <= 1'b1;
          end
        end
        CMD_START: begin
          start_stamp <= item.now_ms;
          last_frame_stamp <= '0;
          frame_count <= '0;
          pos <= '0;
          half <= 1'b0;
          blink_cnt <= '0;
          blink_ph <= 1'b0;
          animating <= 1'b1;
        end
        CMD_STOP, CMD_COLOR: animating <= 1'b0;
        CMD_BRIGHT: begin
          cur_level <= item.level;
          tgt_level <= item.level;
          fading <= 1'b0;
        end
        CMD_FADE: begin
          tgt_level <= item.level;
          fading <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Pixel counter
  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (cmd.idx_clr) idx <= '0;
    else if (cmd.idx_inc) idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
  end

  // Per-pixel brightness through the shared multiplier
  logic [7:0]  phase;
  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic [23:0] prod;
  logic [7:0]  wphase;
  logic [7:0]  wval;
  logic [IW-1:0] pdist;
  logic [10:0] drop;
  logic [7:0]  prog;
  logic [IW-1:0] rdist;
  logic [15:0] third;
  logic [7:0]  b_calc;
  sel_t        sel_calc;

  assign wphase = 8'({frame_count[5:0], 2'b00}) + 8'(8'(idx) * 8'd20);
  assign pdist  = (idx >= CENTER) ? idx - CENTER : CENTER - idx;
  assign drop   = 11'(pdist) * 11'd30;
  assign rdist  = (pos >= idx) ? pos - idx
                               : IW'(({1'b0, pos} + (IW+1)'(PIXELS)) - {1'b0, idx});
  assign third  = 16'(intens) * 16'd171;

  always_comb begin
    case (mode)
      MODE_BREATH: phase = {frame_count[4:0], 3'b000};
      MODE_PULSE:  phase = 8'(frame_count[7:0] * 8'd12);
      default:     phase = wphase;
    endcase
    if (mode == MODE_FADEIN || mode == MODE_FADEOUT) begin
      mul_a = {8'd0, frame_count[7:0]};
      mul_b = fstep;
    end else begin
      mul_a = SINE_ROM[phase];
      mul_b = intens;
    end
  end

  assign prod = 24'(mul_a) * 24'(mul_b);
  assign wval = prod[23:16];

  always_comb begin
    if (frame_count[31:8] != '0) prog = (fstep != '0) ? 8'd255 : 8'd0;
    else prog = (prod[15:0] > 16'd255) ? 8'd255 : prod[7:0];
  end

  always_comb begin
    b_calc = '0;
    sel_calc = SEL_SCALE;
    case (mode)
      MODE_BREATH, MODE_WAVE: b_calc = wval;
      MODE_BLINK: sel_calc = blink_ph ? SEL_ZERO : SEL_RAW;
      MODE_PULSE: b_calc = ({3'b000, wval} > drop) ? 8'({3'b000, wval} - drop) : 8'd0;
      MODE_FADEIN: b_calc = prog;
      MODE_FADEOUT: b_calc = 8'd255 - prog;
      MODE_ROTATE: begin
        if (rdist == '0) sel_calc = SEL_RAW;
        else if (rdist == IW'(1)) b_calc = {1'b0, intens[7:1]};
        else if (rdist == IW'(2)) b_calc = {1'b0, third[15:9]};
        else if (rdist == IW'(3)) b_calc = {2'b00, intens[7:2]};
        else sel_calc = SEL_ZERO;
      end
      default: sel_calc = SEL_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rend_calc) begin
      bright <= b_calc;
      sel <= sel_calc;
    end
  end

  // Color written for the current pixel
  logic [23:0] wcolor;
  always_comb begin
    case (sel)
      SEL_RAW:   wcolor = primary;
      SEL_SCALE: wcolor = scale_rgb(primary, bright);
      default:   wcolor = '0;
    endcase
  end

  // Frame buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIXELS; k++) fb[k] <= '0;
    end else if (cmd.fill_wr) begin
      fb[idx] <= item.color;
    end else if (cmd.rend_wr) begin
      fb[idx] <= wcolor;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_data.pixel_index <= 6'(idx);
      out_data.red <= fb[idx][23:16];
      out_data.green <= fb[idx][15:8];
      out_data.blue <= fb[idx][7:0];
      out_data.global_level <= cur_level;
      out_data.last <= (idx == LAST_IDX);
    end
  end

endmodule

FILE: design/led_strip_animation_engine.sv
// LED strip animation engine. Takes one timestamped command per input transfer
// and keeps an RGB frame buffer of PIXELS entries. A tick renders an animation
// frame when one is due (one brightness step through the shared multiplier and
// one scaled buffer write per pixel), then makes PIXELS output transfers when
// the 20 ms refresh is due. A set-color command sweeps the whole buffer. The
// next command is taken while the last pixel of a refresh still waits in the
// output register. Configuration writes are applied at once and should only be
// made while the block is idle.
module led_strip_animation_engine #(
  parameter int PIXELS           = lsae_pkg::DEF_PIXELS,
  parameter int RESET_BRIGHTNESS = lsae_pkg::DEF_BRIGHTNESS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lsae_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lsae_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import lsae_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lsae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsae_dp #(
    .PIXELS           (PIXELS),
    .RESET_BRIGHTNESS (RESET_BRIGHTNESS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/lsae_chk.sv
module lsae_chk #(
  parameter int PIXELS = lsae_pkg::DEF_PIXELS
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input lsae_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input lsae_pkg::out_item_t out_data,
  input logic                cfg_we,
  input logic [2:0]          cfg_index,
  input logic [23:0]         cfg_data
);
  import lsae_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // Within a refresh, pixels follow one another without gaps
  a_out_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=>
      out_valid && out_data.pixel_index == $past(out_data.pixel_index) + 6'd1)
    else $error("refresh sequence broken");

  // No command taken in the middle of a refresh
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input taken during refresh");

  // The last flag marks the final pixel
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.pixel_index == 6'(PIXELS - 1))
    else $error("last flag on wrong pixel");

endmodule

bind led_strip_animation_engine lsae_chk #(.PIXELS(PIXELS)) u_lsae_chk (.*);

FILE: dv/lsae_checker.sv
module lsae_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lsae_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lsae_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  output int                  errors,
  output int                  pending
);
  import lsae_pkg::*;

  localparam int NPIX = DEF_PIXELS;

  // register copies
  logic [2:0]  mode_r;
  logic [23:0] rgb_r;
  logic [15:0] dur_r;
  logic [15:0] period_r;
  logic [7:0]  intens_r;
  logic        loop_r;
  logic [7:0]  fstep_r;

  // engine state copy
  logic [23:0] pix_buf [NPIX];
  logic [7:0]  cur_lvl;
  logic [7:0]  tgt_lvl;
  logic        fading;
  logic        running;
  logic [31:0] start_ts;
  logic [31:0] frame_ts;
  logic [31:0] frames;
  logic [31:0] refresh_ts;

  logic [15:0] sine_lut [256];
  out_item_t   pixel_q [$];

  assign pending = pixel_q.size();

  // Q0.16 raised sine, Taylor series in Q30
  function automatic logic [15:0] sine_entry(input int unsigned p);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] t;
    logic [63:0] acc;
    logic [63:0] v;
    logic [63:0] q;
    int unsigned k;
    int unsigned m;
    int n;
    k = p % 128;
    m = (k <= 64) ? k : 128 - k;
    ang = 64'(m) * PI_OVER_128_Q30;
    ang2 = (ang * ang) >> 30;
    t = ang;
    acc = ang;
    for (n = 1; n <= 6; n++) begin
      t = ((t * ang2) >> 30) / 64'(2 * n * (2 * n + 1));
      if (n % 2 == 1) acc = acc - t;
      else acc = acc + t;
    end
    if (acc > ONE_Q30) acc = ONE_Q30;
    v = (p >= 128) ? ONE_Q30 - acc : ONE_Q30 + acc;
    q = (v + 64'd16384) >> 15;
    if (q > 64'd65535) q = 64'd65535;
    return q[15:0];
  endfunction

  initial begin
    for (int p = 0; p < 256; p++) sine_lut[p] = sine_entry(p);
  end

  function automatic logic [7:0] wave_amp(input logic [31:0] phase, input logic [7:0] amp);
    logic [31:0] prod;
    prod = 32'(sine_lut[phase[7:0]]) * 32'(amp);
    return prod[23:16];
  endfunction

  function automatic logic [23:0] dim(input logic [23:0] rgb, input logic [7:0] b);
    logic [23:0] r;
    for (int k = 0; k < 3; k++) r[k*8 +: 8] = 8'((16'(rgb[k*8 +: 8]) * 16'(b)) / 16'd255);
    return r;
  endfunction

  task automatic fill_all(input logic [23:0] rgb);
    for (int i = 0; i < NPIX; i++) pix_buf[i] = rgb;
  endtask

  // draw one animation frame into the buffer
  task automatic draw_frame();
    logic [7:0]  pulse;
    logic [31:0] d;
    logic [31:0] drop;
    logic [63:0] prod;
    logic [7:0]  prog;
    int pos;
    int tp;
    case (mode_r)
      MODE_BREATH: fill_all(dim(rgb_r, wave_amp(frames * 8, intens_r)));
      MODE_BLINK: fill_all(((frames / 10) % 2 == 0) ? rgb_r : 24'd0);
      MODE_PULSE: begin
        pulse = wave_amp(frames * 12, intens_r);
        for (int i = 0; i < NPIX; i++) begin
          d = (i >= NPIX / 2) ? i - NPIX / 2 : NPIX / 2 - i;
          drop = d * 30;
          pix_buf[i] = dim(rgb_r, (32'(pulse) > drop) ? 8'(32'(pulse) - drop) : 8'd0);
        end
      end
      MODE_WAVE: begin
        for (int i = 0; i < NPIX; i++)
          pix_buf[i] = dim(rgb_r, wave_amp(frames * 4 + i * 20, intens_r));
      end
      MODE_FADEIN, MODE_FADEOUT: begin
        prod = 64'(frames) * 64'(fstep_r);
        prog = (prod > 64'd255) ? 8'd255 : prod[7:0];
        if (mode_r == MODE_FADEOUT) prog = 8'd255 - prog;
        fill_all(dim(rgb_r, prog));
      end
      MODE_ROTATE: begin
        pos = (frames / 2) % NPIX;
        fill_all(24'd0);
        pix_buf[pos] = rgb_r;
        for (int i = 1; i <= 3; i++) begin
          tp = (pos + NPIX - i) % NPIX;
          pix_buf[tp] = dim(rgb_r, 8'(intens_r / (i + 1)));
        end
      end
      default: ;
    endcase
  endtask

  // apply one command and queue the pixels it sends out
  task automatic apply_command(input in_item_t it);
    out_item_t px;
    case (it.cmd)
      CMD_TICK: begin
        if (fading) begin
          if (cur_lvl < tgt_lvl)
            cur_lvl = (9'(cur_lvl) + 9'd2 > 9'(tgt_lvl)) ? tgt_lvl : cur_lvl + 8'd2;
          else if (cur_lvl > tgt_lvl)
            cur_lvl = (9'(cur_lvl) < 9'(tgt_lvl) + 9'd2) ? tgt_lvl : cur_lvl - 8'd2;
          else
            fading = 1'b0;
        end
        if (running) begin
          if (!loop_r && (it.now_ms - start_ts) >= 32'(dur_r)) begin
            running = 1'b0;
          end else if ((it.now_ms - frame_ts) >= 32'(period_r)) begin
            frame_ts = it.now_ms;
            frames = frames + 1;
            draw_frame();
          end
        end
        if ((it.now_ms - refresh_ts) >= REFRESH_MS) begin
          refresh_ts = it.now_ms;
          for (int i = 0; i < NPIX; i++) begin
            px.pixel_index = 6'(i);
            px.red = pix_buf[i][23:16];
            px.green = pix_buf[i][15:8];
            px.blue = pix_buf[i][7:0];
            px.global_level = cur_lvl;
            px.last = (i == NPIX - 1);
            pixel_q.push_back(px);
          end
        end
      end
      CMD_START: begin
        start_ts = it.now_ms;
        frame_ts = '0;
        frames = '0;
        running = 1'b1;
      end
      CMD_STOP: running = 1'b0;
      CMD_COLOR: begin
        running = 1'b0;
        fill_all(it.color);
      end
      CMD_BRIGHT: begin
        cur_lvl = it.level;
        tgt_lvl = it.level;
        fading = 1'b0;
      end
      CMD_FADE: begin
        tgt_lvl = it.level;
        fading = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_r <= MODE_NONE;
      rgb_r <= '0;
      dur_r <= 16'd1000;
      period_r <= 16'd50;
      intens_r <= 8'd255;
      loop_r <= 1'b0;
      fstep_r <= 8'd5;
      for (int i = 0; i < NPIX; i++) pix_buf[i] = '0;
      cur_lvl = 8'(DEF_BRIGHTNESS);
      tgt_lvl = 8'(DEF_BRIGHTNESS);
      fading = 1'b0;
      running = 1'b0;
      start_ts = '0;
      frame_ts = '0;
      frames = '0;
      refresh_ts = '0;
      pixel_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:     mode_r <= cfg_data[2:0];
          CFG_RGB:      rgb_r <= cfg_data;
          CFG_DURATION: dur_r <= cfg_data[15:0];
          CFG_PERIOD:   period_r <= cfg_data[15:0];
          CFG_INTENS:   intens_r <= cfg_data[7:0];
          CFG_LOOP:     loop_r <= cfg_data[0];
          CFG_FSTEP:    fstep_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) apply_command(in_data);
      // compare output transfer with oldest expected pixel
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          if (errors < 10) $display("unexpected pixel transfer: %p", out_data);
          errors <= errors + 1;
        end else begin
          if (pixel_q[0] !== out_data) begin
            if (errors < 10)
              $display("pixel mismatch: expected %p, got %p", pixel_q[0], out_data);
            errors <= errors + 1;
          end
          void'(pixel_q.pop_front());
        end
      end
    end
  end
endmodule

FILE: dv/testbench.sv
module testbench;
  import lsae_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  int          errors;
  int          pending;
  int          quiet_cycles;
  logic [31:0] now_ms;

  led_strip_animation_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lsae_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver: random gaps, one long hold so the input backs up
  initial begin
    int taken;
    int gap;
    taken = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = (taken == 60) ? 400 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // one input transfer; caller sits at a falling edge
  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] level,
                          input logic [23:0] color);
    int gap;
    in_item_t it;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
    it.cmd = cmd;
    it.now_ms = now_ms;
    it.level = level;
    it.color = color;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic tick(input int unsigned step);
    now_ms = now_ms + step;
    send_cmd(CMD_TICK, 8'($urandom), 24'($urandom));
  endtask

  // drain, let the block settle, then write every register
  task automatic configure(input logic [2:0] mode, input logic [23:0] rgb,
                           input logic [15:0] dur, input logic [15:0] period,
                           input logic [7:0] intens, input logic loop_en,
                           input logic [7:0] fstep);
    logic [23:0] vals [7];
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    vals = '{24'(mode), rgb, 24'(dur), 24'(period), 24'(intens), 24'(loop_en), 24'(fstep)};
    for (int r = 0; r < 7; r++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data <= vals[r];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [2:0] mode;
    logic [15:0] dur;
    logic [15:0] period;
    logic [7:0] intens;
    logic [7:0] fstep;
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    now_ms = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset state, commands, level and color extremes
    tick(0);
    tick(20);
    send_cmd(CMD_BRIGHT, 8'd0, 24'd0);
    tick(19);
    tick(1);
    send_cmd(CMD_COLOR, 8'd0, 24'hFFFFFF);
    send_cmd(CMD_FADE, 8'd255, 24'd0);
    tick(25);
    tick(25);
    send_cmd(CMD_BRIGHT, 8'd255, 24'hFFFFFF);
    send_cmd(CMD_FADE, 8'd0, 24'd0);
    tick(30);
    send_cmd(3'd6, 8'd255, 24'hFFFFFF);
    send_cmd(3'd7, 8'd0, 24'd0);
    send_cmd(CMD_FADE, 8'd255, 24'd0);
    tick(20);
    send_cmd(CMD_START, 8'd0, 24'd0);
    tick(60);
    tick(960);
    tick(20);
    send_cmd(CMD_STOP, 8'd0, 24'd0);
    send_cmd(CMD_COLOR, 8'd0, 24'h000000);
    tick(40);

    // one phase per mode (the first two modes twice), extremes spread over the phases
    for (int ph = 0; ph < 10; ph++) begin
      mode = 3'(ph % 8);
      dur = (ph == 0) ? 16'd0 : (ph == 9) ? 16'hFFFF : 16'($urandom_range(100, 900));
      period = (ph % 3 == 0) ? 16'd0 : (ph == 8) ? 16'hFFFF : 16'($urandom_range(1, 40));
      intens = (ph == 1) ? 8'd0 : (ph == 2) ? 8'd255 : 8'($urandom);
      fstep = (ph == 5) ? 8'd0 : (ph == 6) ? 8'd255 : 8'($urandom_range(1, 40));
      configure(mode, (ph == 4) ? 24'hFFFFFF : 24'($urandom), dur, period, intens,
                (ph % 2 == 1), fstep);
      if (ph == 3) now_ms = 32'hFFFF_FF00;
      else if (ph == 7) now_ms = $urandom;
      send_cmd(CMD_START, 8'd0, 24'd0);
      for (int n = 0; n < 15; n++) begin
        pick = $urandom_range(0, 39);
        if (pick < 30) tick($urandom_range(0, 30));
        else if (pick == 30) send_cmd(CMD_STOP, 8'($urandom), 24'($urandom));
        else if (pick == 31) send_cmd(CMD_COLOR, 8'($urandom), 24'($urandom));
        else if (pick == 32) send_cmd(CMD_BRIGHT, 8'($urandom), 24'($urandom));
        else if (pick <= 34) send_cmd(CMD_FADE, 8'($urandom), 24'($urandom));
        else if (pick == 35) send_cmd(CMD_START, 8'($urandom), 24'($urandom));
        else if (pick == 36) send_cmd(3'($urandom_range(6, 7)), 8'($urandom), 24'($urandom));
        else if (pick == 37) begin
          now_ms = $urandom;
          tick(0);
        end else tick($urandom_range(0, 1500));
      end
    end

    // drain and check
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
